FILE: sv/masked_pattern_scanner_top_macros.svh
// assertion macros for the masked pattern scanner checker
// both expect signals named clk and rst_n in the scope of use
`ifndef MASKED_PATTERN_SCANNER_TOP_MACROS_SVH
`define MASKED_PATTERN_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define MPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// shared widths, register codes and structs of the masked pattern scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mps_pkg;

  localparam int unsigned DATA_W         = 8;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned PATTERN_LANES  = 16;
  localparam int unsigned LANE_W         = 4;
  localparam int unsigned MATCH_OFFSET_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 3'd0,
    CFG_PAT_HI = 3'd1,
    CFG_MSK_LO = 3'd2,
    CFG_MSK_HI = 3'd3,
    CFG_LEN    = 3'd4
  } cfg_reg_t;

  // pattern and mask, one byte per lane, lane 0 is the first pattern byte
  typedef struct packed {
    logic [PATTERN_LANES-1:0][DATA_W-1:0] pat;
    logic [PATTERN_LANES-1:0][DATA_W-1:0] msk;
    logic [LEN_W-1:0]                     len;
  } cfg_t;

  // window control shared by all cells
  typedef struct packed {
    logic shift;
    logic clear;
  } shift_ctrl_t;

endpackage

FILE: sv/mps_stream_if.sv
// ----------------------------------------------------------------------------
// mps_stream_if
// valid/ready channels of the scanner: byte input and match result output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mps_in_if;
  logic                      valid;
  logic                      ready;
  logic [mps_pkg::DATA_W-1:0] data_byte;
  logic                      range_first;

  modport source (output valid, output data_byte, output range_first, input ready);
  modport sink   (input valid, input data_byte, input range_first, output ready);
endinterface

interface mps_out_if;
  logic                              valid;
  logic                              ready;
  logic [mps_pkg::MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, output match_offset, input ready);
  modport sink   (input valid, input match_offset, output ready);
endinterface

FILE: sv/mps_cell.sv
// ----------------------------------------------------------------------------
// mps_cell
// one window byte: holds it, hands it to the next cell, compares its next value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mps_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mps_pkg::shift_ctrl_t          ctrl,
  input  logic [mps_pkg::DATA_W-1:0]    byte_in,
  input  mps_pkg::cfg_t                 cfg,
  input  logic [mps_pkg::LEN_W-1:0]     len_eff,
  output logic [mps_pkg::DATA_W-1:0]    byte_r,
  output logic                          hit
);

  logic [mps_pkg::DATA_W-1:0] byte_nxt;
  logic [mps_pkg::LEN_W-1:0]  lane_full;
  logic                       active;
  logic [mps_pkg::DATA_W-1:0] pat_b;
  logic [mps_pkg::DATA_W-1:0] msk_b;

  // on a range start only the newest cell keeps the incoming byte
  assign byte_nxt = (ctrl.clear && (CELL_IDX != 0)) ? '0 : byte_in;

  // this cell holds the byte that lines up with pattern lane len-1-idx
  assign active    = mps_pkg::LEN_W'(CELL_IDX) < len_eff;
  assign lane_full = len_eff - mps_pkg::LEN_W'(CELL_IDX) - mps_pkg::LEN_W'(1);
  assign pat_b     = cfg.pat[lane_full[mps_pkg::LANE_W-1:0]];
  assign msk_b     = cfg.msk[lane_full[mps_pkg::LANE_W-1:0]];
  assign hit       = !active || ((pat_b & msk_b) == (byte_nxt & msk_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctrl.shift) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

FILE: sv/mps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mps_cfg_regs
// pattern, mask and length registers behind the write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mps_pkg::cfg_t                     cfg
);

  logic [mps_pkg::CFG_DATA_W-1:0] pat_lo_r;
  logic [mps_pkg::CFG_DATA_W-1:0] pat_hi_r;
  logic [mps_pkg::CFG_DATA_W-1:0] msk_lo_r;
  logic [mps_pkg::CFG_DATA_W-1:0] msk_hi_r;
  logic [mps_pkg::LEN_W-1:0]      len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      msk_lo_r <= '0;
      msk_hi_r <= '0;
      len_r    <= '0;
    end else if (cfg_we) begin
      case (mps_pkg::cfg_reg_t'(cfg_index))
        mps_pkg::CFG_PAT_LO: pat_lo_r <= cfg_data;
        mps_pkg::CFG_PAT_HI: pat_hi_r <= cfg_data;
        mps_pkg::CFG_MSK_LO: msk_lo_r <= cfg_data;
        mps_pkg::CFG_MSK_HI: msk_hi_r <= cfg_data;
        mps_pkg::CFG_LEN:    len_r    <= cfg_data[mps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // byte 0 sits in the low bits of the low word
  assign cfg.pat = {pat_hi_r, pat_lo_r};
  assign cfg.msk = {msk_hi_r, msk_lo_r};
  assign cfg.len = len_r;

endmodule

FILE: sv/masked_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// masked_pattern_scanner_top
// streaming search for a masked byte pattern within ranges of memory bytes
// ----------------------------------------------------------------------------
// Bytes enter one per cycle on in_ch; an item with range_first set begins a
// new range. For each non-overlapping, leftmost-first occurrence of the
// configured pattern (1 to 16 bytes, a zero mask bit is a don't-care) that
// lies wholly inside the range, one item leaves on out_ch carrying the
// offset of its first byte from the range start. The result is registered and
// appears in the cycle after the last pattern byte's item is accepted. A new
// byte is taken every cycle: the window compare and shift are done in the
// accept cycle by a row of MAX_PATTERN_BYTES cells, and only a stalled,
// full output register holds off input. No clearing pass after reset.
// Program the registers over cfg_* while the block is idle; a length of
// zero turns matching off, a length above MAX_PATTERN_BYTES acts as
// MAX_PATTERN_BYTES. The offset counter saturates at 2^OFFSET_BITS - 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_pattern_scanner_top #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,  // 1 to 16 cells
  parameter int unsigned OFFSET_BITS       = 32   // 8 to 64 bit byte counter
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mps_in_if.sink                         in_ch,
  mps_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data
);

  // counter wide enough to also form the 32 bit offset without loss
  localparam int unsigned OFS_EXT_W =
    (OFFSET_BITS > mps_pkg::MATCH_OFFSET_W) ? OFFSET_BITS : mps_pkg::MATCH_OFFSET_W;

  mps_pkg::cfg_t                                    cfg;
  mps_pkg::shift_ctrl_t                             ctrl;
  logic [mps_pkg::LEN_W-1:0]                        len_eff;
  logic [MAX_PATTERN_BYTES-1:0][mps_pkg::DATA_W-1:0] win;
  logic [MAX_PATTERN_BYTES-1:0]                     hits;
  logic                                             accept;

  logic [OFFSET_BITS-1:0]            cnt_r, cnt_nxt, cnt_base;
  logic [mps_pkg::LANE_W-1:0]        sup_r, sup_nxt, sup_base;
  logic                              match;
  logic [OFS_EXT_W-1:0]              ofs_ext;
  logic                              out_valid_r;
  logic [mps_pkg::MATCH_OFFSET_W-1:0] out_ofs_r;

  // ---- configuration registers ----
  mps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // overlong length clamps to the number of cells
  assign len_eff = (cfg.len > mps_pkg::LEN_W'(MAX_PATTERN_BYTES)) ?
                   mps_pkg::LEN_W'(MAX_PATTERN_BYTES) : cfg.len;

  // ---- handshake: the output register parts the two sides ----
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.match_offset = out_ofs_r;

  assign ctrl.shift = accept;
  assign ctrl.clear = in_ch.range_first;

  // ---- row of window cells, cell 0 holds the newest byte ----
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [mps_pkg::DATA_W-1:0] nb_in;
    if (k == 0) begin : g_head
      assign nb_in = in_ch.data_byte;
    end else begin : g_link
      assign nb_in = win[k-1];
    end
    mps_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .byte_in (nb_in),
      .cfg     (cfg),
      .len_eff (len_eff),
      .byte_r  (win[k]),
      .hit     (hits[k])
    );
  end

  // ---- byte count and hit suppression ----
  // range start clears both before the new byte counts
  assign cnt_base = in_ch.range_first ? '0 : cnt_r;
  assign sup_base = in_ch.range_first ? '0 : sup_r;
  assign cnt_nxt  = (&cnt_base) ? cnt_base : cnt_base + OFFSET_BITS'(1);

  // a hit needs no pending suppression, a nonzero length and enough bytes
  assign match = (sup_base == '0) && (len_eff != '0) &&
                 (cnt_nxt >= OFFSET_BITS'(len_eff)) && (&hits);

  always_comb begin
    if (sup_base != '0) begin
      sup_nxt = sup_base - mps_pkg::LANE_W'(1);
    end else if (match) begin
      // bytes after the first one of this hit are covered
      sup_nxt = mps_pkg::LANE_W'(len_eff - mps_pkg::LEN_W'(1));
    end else begin
      sup_nxt = '0;
    end
  end

  assign ofs_ext = OFS_EXT_W'(cnt_nxt) - OFS_EXT_W'(len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        sup_r       <= sup_nxt;
        out_valid_r <= match;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a hit
  always_ff @(posedge clk) begin
    if (accept && match) begin
      out_ofs_r <= ofs_ext[mps_pkg::MATCH_OFFSET_W-1:0];
    end
  end

endmodule

FILE: sv/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// port-level checks of the masked pattern scanner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_pattern_scanner_top_macros.svh"

module mps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_range_first,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mps_pkg::MATCH_OFFSET_W-1:0] out_match_offset
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result holds
  `MPS_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_match_offset), "result changed while stalled")

  // a full, stalled output register takes no new byte
  `MPS_ASSERT_IMP(a_in_blocked, out_stall, !in_ready, "input taken while result stalled")

  // every fresh result follows an accepted item
  `MPS_ASSERT_IMP(a_out_cause, out_valid && !$past(out_stall), $past(in_acc), "result with no item")

  // a hit on the first byte of a range can only start at offset zero
  `MPS_ASSERT_IMP(a_first_ofs, out_valid && !$past(out_stall) && $past(in_acc && in_range_first), out_match_offset == '0, "bad offset at range start")

endmodule

bind masked_pattern_scanner_top mps_checker u_mps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_range_first   (in_ch.range_first),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_match_offset (out_ch.match_offset)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the masked pattern scanner
// ----------------------------------------------------------------------------
// Bytes go in over the input channel while a behavioral scanner, kept in step
// with every accepted item, queues the match offsets the block should produce.
// Each result leaving the block is checked against the oldest queued offset.
// A few directed ranges come first, then a hold-off on the result side that
// fills the block, then random phases with planted occurrences under a
// fresh pattern, mask and length each. Random gaps on either side unless turned off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WINDOW_BYTES    = 16;
  localparam longint unsigned COUNT_MAX   = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned BYTES_PER_PHASE = 125;
  localparam int unsigned SHOWN_ERRORS    = 10;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data;

  mps_in_if  in_ch ();
  mps_out_if out_ch ();

  masked_pattern_scanner_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scanner shadow: registers as last written, byte window, range count
  logic [127:0]                       model_pat;
  logic [127:0]                       model_msk;
  logic [mps_pkg::LEN_W-1:0]          model_len;
  logic [7:0]                         recent_bytes [WINDOW_BYTES];
  longint unsigned                    range_count;
  logic [3:0]                         hit_shadow;     // bytes still covered by the last hit
  logic [mps_pkg::MATCH_OFFSET_W-1:0] offsets_due [$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_req     = 0;   // long result hold-off, picked up by the receiver
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one byte through the scanner shadow; queues an offset on a hit
  function automatic void predict_match(input logic [7:0] d, input logic first);
    int unsigned n;
    bit          hit;
    logic [7:0]  p;
    logic [7:0]  m;
    // range start wipes the window, count and suppression before the byte
    if (first) begin
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      range_count = 0;
      hit_shadow  = '0;
    end
    for (int i = WINDOW_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = d;
    // offset counter saturates
    if (range_count < COUNT_MAX) range_count++;
    // lengths past the window act as the full window
    n = (model_len > WINDOW_BYTES) ? WINDOW_BYTES : model_len;
    // bytes inside the previous hit cannot start a new one
    if (hit_shadow != 0) begin
      hit_shadow--;
      return;
    end
    // zero length is off; short ranges cannot hold the pattern yet
    if (n == 0 || range_count < n) return;
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      p = model_pat[8*i +: 8];
      m = model_msk[8*i +: 8];
      // pattern byte i sits n-1-i places behind the newest byte
      if ((p & m) != (recent_bytes[n-1-i] & m)) hit = 1'b0;
    end
    if (!hit) return;
    hit_shadow = 4'(n - 1);
    offsets_due.push_back(mps_pkg::MATCH_OFFSET_W'(range_count - n));
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("%s", msg);
  endfunction

  // input accepts feed the shadow, output accepts are checked
  always @(posedge clk) begin : check_results
    logic [mps_pkg::MATCH_OFFSET_W-1:0] want;
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_match(in_ch.data_byte, in_ch.range_first);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (offsets_due.size() == 0) begin
        note_failure($sformatf("unexpected match result: match_offset %0d",
                               out_ch.match_offset));
      end else begin
        want = offsets_due.pop_front();
        if (out_ch.match_offset !== want)
          note_failure($sformatf("match_offset mismatch: expected %0d, got %0d",
                                 want, out_ch.match_offset));
      end
    end
  end

  // no accepts on either side for too long ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus the long hold-off on request
  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        // mostly short stalls, now and then a long one
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // offer one item, wait for its accept, then maybe idle a while
  task automatic send_byte(input logic [7:0] d, input logic first);
    int unsigned gap;
    int unsigned r;
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.range_first <= first;
    do @(posedge clk); while (!in_ch.ready);
    gap = 0;
    if (sender_idles) begin
      r = $urandom_range(0, 99);
      if (r >= 92)      gap = $urandom_range(8, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    // valid stays up when the next item follows at once
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering items and let every pending result drain out
  task automatic settle();
    in_ch.valid <= 1'b0;
    // the last accept is predicted and registered by the next edge
    @(posedge clk);
    while (offsets_due.size() != 0 || out_ch.valid) @(posedge clk);
    // a byte with no hit may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input mps_pkg::cfg_reg_t idx,
                           input logic [mps_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mps_pkg::CFG_PAT_LO: model_pat[63:0]   = val;
      mps_pkg::CFG_PAT_HI: model_pat[127:64] = val;
      mps_pkg::CFG_MSK_LO: model_msk[63:0]   = val;
      mps_pkg::CFG_MSK_HI: model_msk[127:64] = val;
      mps_pkg::CFG_LEN:    model_len         = val[mps_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // all five registers, block must be idle
  task automatic load_pattern(input logic [127:0] pat, input logic [127:0] msk,
                              input logic [mps_pkg::LEN_W-1:0] len);
    write_reg(mps_pkg::CFG_PAT_LO, pat[63:0]);
    write_reg(mps_pkg::CFG_PAT_HI, pat[127:64]);
    write_reg(mps_pkg::CFG_MSK_LO, msk[63:0]);
    write_reg(mps_pkg::CFG_MSK_HI, msk[127:64]);
    write_reg(mps_pkg::CFG_LEN, mps_pkg::CFG_DATA_W'(len));
  endtask

  // bytes before any range mark count from reset; hits do not overlap
  task automatic test_no_range_mark();
    settle();
    load_pattern(128'h5AA5, 128'hFFFF, 5'd2);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // a range cut short by a new range mark never matches across the cut
  task automatic test_range_restart();
    settle();
    load_pattern(128'h33_22_11, 128'hFF_FF_FF, 5'd3);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
  endtask

  // half-byte wildcards: high nibble of byte 0, low nibble of byte 1 compared
  task automatic test_nibble_wildcards();
    settle();
    load_pattern(128'h00FF, 128'h0FF0, 5'd2);
    send_byte(8'hF3, 1'b1);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
  endtask

  // all registers zero: length zero means no results at all
  task automatic test_zero_length();
    settle();
    load_pattern('0, '0, 5'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // every byte a hit while results are held back: input must stall
  task automatic test_output_backpressure();
    settle();
    load_pattern({$urandom, $urandom, $urandom, $urandom}, '0, 5'd1);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    hold_req        = 150;
    repeat (30) send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
  endtask

  // phases of random settings, mostly planted occurrences with random fill
  task automatic test_random_scans();
    logic [127:0]              pat;
    logic [127:0]              msk;
    logic [mps_pkg::LEN_W-1:0] len;
    logic [7:0]                b;
    int unsigned               n;
    int unsigned               sent;
    int unsigned               pick;
    int unsigned               spoil;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pat = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0, 1:    msk[8*i +: 8] = 8'hFF;
          2:       msk[8*i +: 8] = 8'h00;
          3:       msk[8*i +: 8] = 8'hF0;
          4:       msk[8*i +: 8] = 8'h0F;
          default: msk[8*i +: 8] = 8'($urandom);
        endcase
      end
      len = mps_pkg::LEN_W'($urandom_range(1, WINDOW_BYTES));
      // first phases pin the extremes
      case (ph)
        0: begin
          pat = '1;
          msk = '1;
          len = 5'd16;
        end
        1: begin
          pat = '0;
          msk = '0;
          len = 5'd31;    // overlong and all wildcard
        end
        2: len = 5'd0;
        3: len = 5'd1;
        4: len = mps_pkg::LEN_W'($urandom_range(17, 31));
        default: ;
      endcase
      settle();
      load_pattern(pat, msk, len);
      // some phases run without any idling
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      n    = (len > WINDOW_BYTES) ? WINDOW_BYTES : len;
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        if (n > 0 && $urandom_range(0, 99) < 60) begin
          // planted occurrence: wildcard bits random, now and then one byte spoiled
          spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : WINDOW_BYTES;
          for (int i = 0; i < n; i++) begin
            b = (pat[8*i +: 8] & msk[8*i +: 8]) | (8'($urandom) & ~msk[8*i +: 8]);
            if (i == spoil) b = 8'($urandom);
            send_byte(b, ($urandom_range(0, 99) < 3));
            sent++;
          end
        end else begin
          send_byte(8'($urandom), ($urandom_range(0, 99) < 3));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= mps_pkg::CFG_PAT_LO;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.range_first <= 1'b0;
    // shadow starts from the reset state
    model_pat   = '0;
    model_msk   = '0;
    model_len   = '0;
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
    range_count = 0;
    hit_shadow  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_range_mark();
    test_range_restart();
    test_nibble_wildcards();
    test_zero_length();
    test_output_backpressure();
    test_random_scans();

    // drain, then keep watching the output for stray results
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/mps_pkg.sv
sv/mps_stream_if.sv
sv/mps_cell.sv
sv/mps_cfg_regs.sv
sv/masked_pattern_scanner_top.sv
sv/mps_checker.sv
test/tb.sv
